@@ rtl/fpgm_pkg.sv @@
// ----------------------------------------------------------------------------
// fpgm_pkg
// Types, constants and helpers shared by the packet gap monitor modules.
// ----------------------------------------------------------------------------
package fpgm_pkg;

  localparam int GAP_BINS    = 1024;
  localparam int BIN_W       = $clog2(GAP_BINS);
  localparam int NUM_CLASSES = 9;
  localparam int CLASS_W     = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_INDEX_W = 8;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_PROTOCOL = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_SRC_ADDR = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_DST_ADDR = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_PORTS    = 8'd3;

  localparam logic [31:0] CLASS_BOUNDS [NUM_CLASSES-1] = '{
    32'd2, 32'd5, 32'd20, 32'd50, 32'd100, 32'd200, 32'd500, 32'd1000
  };

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } fpgm_in_t;

  typedef struct packed {
    logic [31:0]        packet_index;
    logic               is_tcp_or_udp;
    logic [31:0]        udp_gap;
    logic [31:0]        tcp_gap;
    logic               target_match;
    logic [31:0]        target_gap;
    logic [CLASS_W-1:0] gap_class;
    logic [31:0]        class_count;
    logic [31:0]        exact_count;
  } fpgm_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [31:0]        packet_index;
    logic               is_tcp_or_udp;
    logic [31:0]        udp_gap;
    logic [31:0]        tcp_gap;
    logic               target_match;
    logic [31:0]        target_gap;
    logic [CLASS_W-1:0] gap_class;
    logic               hist_en;
    logic [BIN_W-1:0]   bin;
  } fpgm_rec_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } fpgm_qstat_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // bounds are ascending, so the class is the last bound reached
  function automatic logic [CLASS_W-1:0] gap_classify(input logic [31:0] gap);
    logic [CLASS_W-1:0] c;
    c = '0;
    for (int i = 0; i < NUM_CLASSES - 1; i++) begin
      if (gap >= CLASS_BOUNDS[i]) c = CLASS_W'(i + 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/fpgm_ram.sv @@
// ----------------------------------------------------------------------------
// fpgm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fpgm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/fpgm_front.sv @@
// ----------------------------------------------------------------------------
// fpgm_front
// Counts packets, holds the target registers, computes gaps and the class.
// ----------------------------------------------------------------------------
module fpgm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fpgm_pkg::fpgm_in_t    in_data,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  output fpgm_pkg::fpgm_rec_t   rec
);
  import fpgm_pkg::*;

  logic [7:0]  tgt_proto_r;
  logic [31:0] tgt_saddr_r;
  logic [31:0] tgt_daddr_r;
  logic [31:0] tgt_ports_r;
  logic [31:0] cnt_r;
  logic [31:0] last_target_r;
  logic        seen_r;
  logic [31:0] last_udp_r;
  logic [31:0] last_tcp_r;

  logic [31:0] cnt_inc;
  logic [31:0] tgap;
  logic        is_tcp;
  logic        is_udp;
  logic        match;

  always_comb begin
    cnt_inc = cnt_r + 32'd1;
    tgap    = cnt_inc - last_target_r;
    is_tcp  = (in_data.protocol == PROTO_TCP);
    is_udp  = (in_data.protocol == PROTO_UDP);
    match   = (is_tcp || is_udp) && (in_data.protocol == tgt_proto_r) &&
              (in_data.source_address == tgt_saddr_r) &&
              (in_data.dest_address == tgt_daddr_r) &&
              ({in_data.source_port, in_data.dest_port} == tgt_ports_r);

    rec               = '0;
    rec.packet_index  = cnt_inc;
    rec.is_tcp_or_udp = is_tcp || is_udp;
    rec.udp_gap       = is_udp ? cnt_inc - last_udp_r : '0;
    rec.tcp_gap       = is_tcp ? cnt_inc - last_tcp_r : '0;
    rec.target_match  = match;
    if (match) begin
      rec.target_gap = tgap;
      rec.gap_class  = gap_classify(tgap);
      rec.hist_en    = seen_r;
      rec.bin        = (tgap >= 32'(GAP_BINS - 1)) ? BIN_W'(GAP_BINS - 1)
                                                   : tgap[BIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_proto_r   <= '0;
      tgt_saddr_r   <= '0;
      tgt_daddr_r   <= '0;
      tgt_ports_r   <= '0;
      cnt_r         <= '0;
      last_target_r <= '0;
      seen_r        <= 1'b0;
      last_udp_r    <= '0;
      last_tcp_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_PROTOCOL: tgt_proto_r <= cfg_data[7:0];
          CFG_TARGET_SRC_ADDR: tgt_saddr_r <= cfg_data;
          CFG_TARGET_DST_ADDR: tgt_daddr_r <= cfg_data;
          CFG_TARGET_PORTS:    tgt_ports_r <= cfg_data;
          default: ;
        endcase
      end
      if (push) begin
        cnt_r <= cnt_inc;
        if (match) begin
          last_target_r <= cnt_inc;
          seen_r        <= 1'b1;
        end
        if (is_udp) last_udp_r <= cnt_inc;
        if (is_tcp) last_tcp_r <= cnt_inc;
      end
    end
  end

endmodule

@@ rtl/fpgm_queue.sv @@
// ----------------------------------------------------------------------------
// fpgm_queue
// Short register queue between the classifying front and the counting back.
// ----------------------------------------------------------------------------
module fpgm_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fpgm_pkg::fpgm_rec_t   push_rec,
  input  logic                  pop,
  output fpgm_pkg::fpgm_rec_t   head_rec,
  output fpgm_pkg::fpgm_qstat_t stat
);
  import fpgm_pkg::*;

  fpgm_rec_t          q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W:0]    count_r;
  logic [QPTR_W:0]    count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_rec;
  end

  assign head_rec      = q_r[rd_ptr_r];
  assign stat.full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.nonempty = (count_r != '0);

endmodule

@@ rtl/fpgm_back.sv @@
// ----------------------------------------------------------------------------
// fpgm_back
// Updates class counters and the exact-gap histogram, drives the result.
// ----------------------------------------------------------------------------
module fpgm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fpgm_pkg::fpgm_rec_t   head_rec,
  input  fpgm_pkg::fpgm_qstat_t qstat,
  output logic                  pop,
  output logic                  clearing,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fpgm_pkg::fpgm_out_t   out_data
);
  import fpgm_pkg::*;

  logic             clearing_r;
  logic [BIN_W-1:0] clr_addr_r;

  logic             b1_valid_r;
  fpgm_rec_t        b1_r;
  logic             b1_adv;

  logic             fwd_valid_r;
  logic [BIN_W-1:0] fwd_addr_r;
  logic [31:0]      fwd_data_r;

  logic [31:0]      cls_cnt_r [NUM_CLASSES];
  logic [31:0]      cc_old;
  logic [31:0]      cc_new;

  logic             ram_we;
  logic [BIN_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic [31:0]      ram_rdata;
  logic [31:0]      hist_old;
  logic [31:0]      hist_new;

  logic             out_valid_r;
  fpgm_out_t        out_data_r;

  assign b1_adv = b1_valid_r && (!out_valid_r || out_ready);
  assign pop    = qstat.nonempty && !clearing_r && (!b1_valid_r || b1_adv);

  always_comb begin
    // the last write can land at the same edge as this entry's read
    hist_old = (fwd_valid_r && (fwd_addr_r == b1_r.bin)) ? fwd_data_r : ram_rdata;
    hist_new = sat_inc(hist_old);
    cc_old   = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (b1_r.gap_class == CLASS_W'(i)) cc_old = cls_cnt_r[i];
    end
    cc_new   = sat_inc(cc_old);
  end

  assign ram_we    = clearing_r || (b1_adv && b1_r.hist_en);
  assign ram_waddr = clearing_r ? clr_addr_r : b1_r.bin;
  assign ram_wdata = clearing_r ? 32'd0 : hist_new;

  fpgm_ram #(
    .WIDTH (32),
    .DEPTH (GAP_BINS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (head_rec.bin),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      b1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) cls_cnt_r[i] <= '0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == BIN_W'(GAP_BINS - 1)) clearing_r <= 1'b0;
      end
      if (pop) begin
        b1_valid_r <= 1'b1;
      end else if (b1_adv) begin
        b1_valid_r <= 1'b0;
      end
      if (b1_adv) begin
        fwd_valid_r <= b1_r.hist_en;
        out_valid_r <= 1'b1;
        for (int i = 0; i < NUM_CLASSES; i++) begin
          if (b1_r.target_match && (b1_r.gap_class == CLASS_W'(i))) cls_cnt_r[i] <= cc_new;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) b1_r <= head_rec;
    if (b1_adv) begin
      fwd_addr_r               <= b1_r.bin;
      fwd_data_r               <= hist_new;
      out_data_r.packet_index  <= b1_r.packet_index;
      out_data_r.is_tcp_or_udp <= b1_r.is_tcp_or_udp;
      out_data_r.udp_gap       <= b1_r.udp_gap;
      out_data_r.tcp_gap       <= b1_r.tcp_gap;
      out_data_r.target_match  <= b1_r.target_match;
      out_data_r.target_gap    <= b1_r.target_gap;
      out_data_r.gap_class     <= b1_r.gap_class;
      out_data_r.class_count   <= b1_r.target_match ? cc_new : 32'd0;
      out_data_r.exact_count   <= b1_r.hist_en ? hist_new : 32'd0;
    end
  end

  assign clearing  = clearing_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/flow_packet_gap_monitor.sv @@
// ----------------------------------------------------------------------------
// flow_packet_gap_monitor
// Per-packet protocol gaps and target-flow gap classes with histograms.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_data   (fpgm_in_t)
//   out     | output    | out_valid / out_ready | out_data  (fpgm_out_t)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one request per cycle sustained while out_ready stays high; a result goes
// through the queue write at accept, histogram ram read and output register
// after reset all GAP_BINS (1024) histogram ram entries are swept to zero,
// with in_ready low; cfg writes are taken throughout
// the four-entry queue keeps in_ready high, until it fills, through an out_ready stall
// ----------------------------------------------------------------------------
module flow_packet_gap_monitor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fpgm_pkg::fpgm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fpgm_pkg::fpgm_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import fpgm_pkg::*;

  fpgm_rec_t   front_rec;
  fpgm_rec_t   head_rec;
  fpgm_qstat_t qstat;
  logic        push;
  logic        pop;
  logic        clearing;

  assign cfg_ready = 1'b1;
  assign in_ready  = !qstat.full && !clearing;
  assign push      = in_valid && in_ready;

  fpgm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rec       (front_rec)
  );

  fpgm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (front_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (qstat)
  );

  fpgm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_rec  (head_rec),
    .qstat     (qstat),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/fpgm_checker.sv @@
// ----------------------------------------------------------------------------
// fpgm_checker
// Port-level checks of the packet gap monitor, bound to the top level.
// ----------------------------------------------------------------------------
module fpgm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fpgm_pkg::fpgm_out_t out_data
);
  import fpgm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // histogram sweep keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during histogram clear");

  a_other_proto: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_tcp_or_udp |->
      out_data.udp_gap == 32'd0 && out_data.tcp_gap == 32'd0 && !out_data.target_match)
    else $error("non tcp/udp result carries gaps");

  a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.target_match |->
      out_data.gap_class == '0 && out_data.class_count == 32'd0 &&
      out_data.exact_count == 32'd0)
    else $error("target fields set without match");

  a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.target_match |->
      out_data.class_count != 32'd0 && out_data.gap_class <= CLASS_W'(NUM_CLASSES - 1))
    else $error("matched result with bad class or count");

endmodule

bind flow_packet_gap_monitor fpgm_checker u_fpgm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ test/fpgm_gap_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fpgm_gap_checker
// Watches the config, packet and result channels of the packet gap monitor,
// keeps its own copy of the flow state, predicts every result and compares.
// ----------------------------------------------------------------------------
module fpgm_gap_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  fpgm_pkg::fpgm_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  fpgm_pkg::fpgm_out_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int unsigned         mismatches,
  output int unsigned         outstanding
);
  import fpgm_pkg::*;

  localparam int unsigned GAP_LIMITS [NUM_CLASSES-1] = '{2, 5, 20, 50, 100, 200, 500, 1000};

  // followed flow
  logic [7:0]  flow_proto;
  logic [31:0] flow_saddr;
  logic [31:0] flow_daddr;
  logic [31:0] flow_ports;

  logic [31:0] pkt_count;
  logic [31:0] last_match_idx;
  logic        match_seen;
  logic [31:0] last_udp_idx;
  logic [31:0] last_tcp_idx;
  logic [31:0] class_tally [NUM_CLASSES];
  logic [31:0] bin_tally [GAP_BINS];

  fpgm_out_t expected_reports [$];

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // advances the flow state by one packet and returns its report
  function automatic fpgm_out_t gap_report_for(input fpgm_in_t p);
    fpgm_out_t r;
    logic [31:0] gap;
    logic [CLASS_W-1:0] cls;
    int unsigned bin;
    r = '0;
    pkt_count = pkt_count + 32'd1;
    r.packet_index = pkt_count;
    if (p.protocol != PROTO_TCP && p.protocol != PROTO_UDP) return r;
    r.is_tcp_or_udp = 1'b1;
    if (p.protocol == flow_proto && p.source_address == flow_saddr &&
        p.dest_address == flow_daddr && {p.source_port, p.dest_port} == flow_ports) begin
      gap = pkt_count - last_match_idx;
      cls = '0;
      while (cls < NUM_CLASSES - 1 && gap >= GAP_LIMITS[cls]) cls++;
      last_match_idx = pkt_count;
      class_tally[cls] = bump(class_tally[cls]);
      r.target_match = 1'b1;
      r.target_gap = gap;
      r.gap_class = cls;
      r.class_count = class_tally[cls];
      if (match_seen) begin
        bin = (gap >= GAP_BINS - 1) ? GAP_BINS - 1 : gap;
        bin_tally[bin] = bump(bin_tally[bin]);
        r.exact_count = bin_tally[bin];
      end
      match_seen = 1'b1;
    end
    if (p.protocol == PROTO_UDP) begin
      r.udp_gap = pkt_count - last_udp_idx;
      last_udp_idx = pkt_count;
    end else begin
      r.tcp_gap = pkt_count - last_tcp_idx;
      last_tcp_idx = pkt_count;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_report(input fpgm_out_t want, input fpgm_out_t got);
    check_field("packet_index", want.packet_index, got.packet_index);
    check_field("is_tcp_or_udp", 32'(want.is_tcp_or_udp), 32'(got.is_tcp_or_udp));
    check_field("udp_gap", want.udp_gap, got.udp_gap);
    check_field("tcp_gap", want.tcp_gap, got.tcp_gap);
    check_field("target_match", 32'(want.target_match), 32'(got.target_match));
    check_field("target_gap", want.target_gap, got.target_gap);
    check_field("gap_class", 32'(want.gap_class), 32'(got.gap_class));
    check_field("class_count", want.class_count, got.class_count);
    check_field("exact_count", want.exact_count, got.exact_count);
  endtask

  always @(posedge clk) begin
    fpgm_out_t want;
    if (!rst_n) begin
      flow_proto = '0;
      flow_saddr = '0;
      flow_daddr = '0;
      flow_ports = '0;
      pkt_count = '0;
      last_match_idx = '0;
      match_seen = 1'b0;
      last_udp_idx = '0;
      last_tcp_idx = '0;
      for (int i = 0; i < NUM_CLASSES; i++) class_tally[i] = '0;
      for (int i = 0; i < GAP_BINS; i++) bin_tally[i] = '0;
      expected_reports.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TARGET_PROTOCOL: flow_proto = cfg_data[7:0];
          CFG_TARGET_SRC_ADDR: flow_saddr = cfg_data;
          CFG_TARGET_DST_ADDR: flow_daddr = cfg_data;
          CFG_TARGET_PORTS:    flow_ports = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_reports.push_back(gap_report_for(in_data));
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("result 0x%08h arrived with nothing pending", out_data.packet_index);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          compare_report(want, out_data);
        end
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives packet headers and target writes into the gap monitor: directed
// corner cases, random flow traffic with stalls on both sides, a target that
// can never match and a long gap on an all-zero flow.
// ----------------------------------------------------------------------------
module tb_top;
  import fpgm_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = 8'hFF;
  localparam int RANDOM_ITEMS  = 200;
  localparam int LONG_GAP      = 210;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_AT       = 200;
  localparam int HOLD_CYCLES   = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  fpgm_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  fpgm_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;
  int unsigned mismatches;
  int unsigned outstanding;

  logic        idle_on;
  int unsigned sent_total;

  flow_packet_gap_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fpgm_gap_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic fpgm_in_t pkt(input logic [7:0] proto, input logic [31:0] sa,
                                   input logic [31:0] da, input logic [15:0] sp,
                                   input logic [15:0] dp);
    fpgm_in_t p;
    p.protocol = proto;
    p.source_address = sa;
    p.dest_address = da;
    p.source_port = sp;
    p.dest_port = dp;
    return p;
  endfunction

  // traffic that is not the followed flow, some of it one bit away from it
  function automatic fpgm_in_t stray_packet(input fpgm_in_t flow);
    fpgm_in_t p;
    logic [95:0] tuple;
    p = pkt(8'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom));
    case ($urandom_range(0, 5))
      0: ;
      1: p.protocol = PROTO_TCP;
      2: p.protocol = PROTO_UDP;
      3: begin
        p = flow;
        tuple = {flow.source_address, flow.dest_address, flow.source_port, flow.dest_port};
        tuple = tuple ^ (96'd1 << $urandom_range(0, 95));
        {p.source_address, p.dest_address, p.source_port, p.dest_port} = tuple;
      end
      4: begin
        p = flow;
        p.protocol = (flow.protocol == PROTO_TCP) ? PROTO_UDP : PROTO_TCP;
      end
      default: begin
        p.protocol = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
        p.protocol = p.protocol ^ (8'd1 << $urandom_range(0, 7));
      end
    endcase
    return p;
  endfunction

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_target(input fpgm_in_t flow);
    write_reg(CFG_TARGET_PROTOCOL, 32'(flow.protocol));
    write_reg(CFG_TARGET_SRC_ADDR, flow.source_address);
    write_reg(CFG_TARGET_DST_ADDR, flow.dest_address);
    write_reg(CFG_TARGET_PORTS, {flow.source_port, flow.dest_port});
  endtask

  task automatic send(input fpgm_in_t p);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_total++;
  endtask

  // valid is dropped at the accepting edge, then every result must drain
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls plus one long hold that backs up the block
  initial begin
    int unsigned taken;
    bit held;
    taken = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (taken >= HOLD_AT && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    fpgm_in_t flow;
    int unsigned start;
    int unsigned gap;
    int unsigned r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    sent_total = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tcp flow at the address and port extremes
    flow = pkt(PROTO_TCP, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0);
    set_target(flow);
    write_reg(CFG_UNMAPPED_LO, $urandom);
    write_reg(CFG_UNMAPPED_HI, $urandom);
    send(pkt(8'h00, 32'h0, 32'h0, 16'h0, 16'h0));
    send(pkt(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    send(pkt(PROTO_UDP, $urandom, $urandom, 16'($urandom), 16'($urandom)));
    send(pkt(PROTO_TCP, $urandom, $urandom, 16'($urandom), 16'($urandom)));
    send(flow);  // first match, no histogram update
    send(flow);
    send(pkt(PROTO_UDP, flow.source_address, flow.dest_address, flow.source_port,
             flow.dest_port));
    send(flow);
    send(pkt(PROTO_TCP, 32'hFFFF_FFFE, 32'h0, 16'hFFFF, 16'h0));
    send(pkt(PROTO_TCP, 32'hFFFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'h0));
    send(pkt(PROTO_TCP, 32'hFFFF_FFFF, 32'h0, 16'hFFFE, 16'h0));
    send(pkt(PROTO_TCP, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h1));
    send(flow);
    send(pkt(8'd5, flow.source_address, 32'h0, 16'hFFFF, 16'h0));
    send(pkt(8'd7, flow.source_address, 32'h0, 16'hFFFF, 16'h0));
    send(pkt(8'd16, flow.source_address, 32'h0, 16'hFFFF, 16'h0));
    send(pkt(8'd18, flow.source_address, 32'h0, 16'hFFFF, 16'h0));
    send(flow);
    send(flow);
    send(pkt(PROTO_TCP, 32'h0, 32'h0, 16'h0, 16'h0));
    send(pkt(PROTO_UDP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    send(flow);
    drain();

    // random udp flow with gaps spread across the lower classes
    flow = pkt(PROTO_UDP, $urandom, $urandom, 16'($urandom), 16'($urandom));
    set_target(flow);
    start = sent_total;
    while (sent_total - start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 15);
      if (r < 10) gap = $urandom_range(1, 4);
      else if (r < 13) gap = $urandom_range(5, 19);
      else if (r == 13) gap = $urandom_range(20, 49);
      else if (r == 14) gap = $urandom_range(50, 99);
      else gap = $urandom_range(100, 300);
      repeat (gap - 1) send(stray_packet(flow));
      send(flow);
    end
    drain();

    // a target protocol that is neither tcp nor udp never matches
    flow = pkt(8'hFF, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF);
    set_target(flow);
    send(flow);
    send(pkt(PROTO_TCP, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF));
    send(pkt(PROTO_UDP, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF));
    send(pkt(8'd1, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF));
    repeat (8) send(stray_packet(flow));
    send(flow);
    idle_on <= 1'b0;
    drain();

    // all-zero udp flow, one long gap then back-to-back matches
    flow = pkt(PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0);
    set_target(flow);
    send(flow);
    repeat (LONG_GAP - 1) send(stray_packet(flow));
    send(flow);
    send(flow);
    send(flow);
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d packets: header extremes, tcp/udp near misses, random flow gaps",
             sent_total);
    $display("with a long result stall, a never-matching target and a long all-zero gap");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
